/* sv/tpn_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tpn_pkg
// shared types, constants and helpers of the track patrol navigator
// ----------------------------------------------------------------------------
package tpn_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 88;

   localparam int MAX_SHIFT     = 800;
   localparam int STRIKES       = 3;
   localparam int SWEEP_HALF_X  = 1600;
   localparam int SWEEP_HALF_Y  = 1600;
   localparam int WORSE_MARGIN  = 6;

   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_WIDTH   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_HEIGHT  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CENTER_TOL    = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_HOVER_RELEASE = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_REAIM_MS      = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOST_GRACE_MS = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_X        = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_Y        = 3'd7;

   localparam logic [1:0] MODE_PATROL   = 2'd0;
   localparam logic [1:0] MODE_APPROACH = 2'd1;
   localparam logic [1:0] MODE_HOVER    = 2'd2;

   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_FRAME = 1'b1;

   typedef enum logic [2:0] {
      ST_PATROL   = 3'b001,
      ST_APPROACH = 3'b010,
      ST_HOVER    = 3'b100
   } nav_state_type;

   typedef struct packed {
      logic signed [23:0] x;
      logic signed [23:0] y;
   } point_type;

   localparam logic signed [23:0] PHX = 24'(SWEEP_HALF_X);
   localparam logic signed [23:0] PHY = 24'(SWEEP_HALF_Y);
   localparam logic signed [22:0] SHIFT_HI = 23'(MAX_SHIFT);
   localparam logic signed [22:0] SHIFT_LO = -23'(MAX_SHIFT);

   function automatic logic [1:0] mode_code(nav_state_type s);
      logic [1:0] m;
      case (s)
         ST_APPROACH: m = MODE_APPROACH;
         ST_HOVER:    m = MODE_HOVER;
         default:     m = MODE_PATROL;
      endcase
      return m;
   endfunction

   function automatic point_type patrol_point(logic [2:0] slot);
      point_type p;
      case (slot)
         3'd0:    begin p.x = -PHX; p.y = -PHY; end
         3'd1:    begin p.x = PHX;  p.y = PHY;  end
         3'd3:    begin p.x = PHX;  p.y = -PHY; end
         3'd4:    begin p.x = -PHX; p.y = PHY;  end
         default: begin p.x = '0;   p.y = '0;   end
      endcase
      return p;
   endfunction

   function automatic logic signed [15:0] clamp_shift(logic signed [22:0] v);
      logic signed [22:0] c;
      if (v > SHIFT_HI) c = SHIFT_HI;
      else if (v < SHIFT_LO) c = SHIFT_LO;
      else c = v;
      return c[15:0];
   endfunction

   function automatic logic signed [23:0] sat24(logic signed [24:0] v);
      logic signed [23:0] r;
      if (v[24] != v[23]) r = v[24] ? 24'sh800000 : 24'sh7fffff;
      else r = v[23:0];
      return r;
   endfunction

   function automatic logic [13:0] abs14(logic signed [13:0] v);
      return v[13] ? 14'(-v) : 14'(v);
   endfunction

   function automatic logic [3:0] strike(logic [3:0] cnt, logic [13:0] abs_e,
                                         logic [13:0] abs_prev);
      logic [3:0] r;
      if ({1'b0, abs_e} > {1'b0, abs_prev} + 15'(WORSE_MARGIN))
         r = (cnt == 4'd15) ? cnt : cnt + 4'd1;
      else
         r = '0;
      return r;
   endfunction

endpackage
`default_nettype wire

/* sv/track_patrol_navigator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// track_patrol_navigator
// patrol, approach and hover mode machine for a camera platform
// ----------------------------------------------------------------------------
// flow: a frame beat is registered, evaluated and loaded into the result
// register; tick beats update the ms counters, no result. throughput: one
// beat per cycle unless a held result stalls a frame beat, set by the single
// compute stage between the two registers (one 14x16 multiply per axis)
// reset: synchronous, restores the default registers and clears all state
module track_patrol_navigator
   import tpn_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   csr_we,
   input  wire  [CSR_ADDR_W-1:0] csr_addr,
   input  wire  [CSR_DATA_W-1:0] csr_wdata,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   // found, obj_x, obj_y, pos_x, pos_y, busy, zero pad
   input  wire  [REQ_DATA_W-1:0] req_tdata,
   // kind
   input  wire                   req_tuser,
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   // mode, abort_move, move_valid, target_x, target_y, shift_x, shift_y,
   // warn_x, warn_y, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // configuration
   logic [11:0]        frame_width_ff, frame_height_ff, center_tol_ff, hover_release_ff;
   logic [15:0]        reaim_ms_ff, lost_grace_ms_ff;
   logic signed [15:0] gain_x_ff, gain_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= 12'd1280;
         frame_height_ff  <= 12'd720;
         center_tol_ff    <= 12'd20;
         hover_release_ff <= 12'd40;
         reaim_ms_ff      <= 16'd200;
         lost_grace_ms_ff <= 16'd2000;
         gain_x_ff        <= 16'sd256;
         gain_y_ff        <= 16'sd256;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_FRAME_WIDTH:   frame_width_ff   <= csr_wdata[11:0];
            CSR_FRAME_HEIGHT:  frame_height_ff  <= csr_wdata[11:0];
            CSR_CENTER_TOL:    center_tol_ff    <= csr_wdata[11:0];
            CSR_HOVER_RELEASE: hover_release_ff <= csr_wdata[11:0];
            CSR_REAIM_MS:      reaim_ms_ff      <= csr_wdata;
            CSR_LOST_GRACE_MS: lost_grace_ms_ff <= csr_wdata;
            CSR_GAIN_X:        gain_x_ff        <= csr_wdata;
            CSR_GAIN_Y:        gain_y_ff        <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   logic               s1_valid_ff, s1_kind_ff, s1_found_ff, s1_busy_ff;
   logic [11:0]        s1_obj_x_ff, s1_obj_y_ff;
   logic signed [23:0] s1_pos_x_ff, s1_pos_y_ff;
   logic               s1_fire, out_free, req_fire;

   assign out_free   = !rsp_tvalid || rsp_tready;
   assign s1_fire    = s1_valid_ff && (s1_kind_ff == KIND_TICK || out_free);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (req_tready) s1_valid_ff <= req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_kind_ff  <= req_tuser;
         s1_found_ff <= req_tdata[0];
         s1_obj_x_ff <= req_tdata[12:1];
         s1_obj_y_ff <= req_tdata[24:13];
         s1_pos_x_ff <= req_tdata[48:25];
         s1_pos_y_ff <= req_tdata[72:49];
         s1_busy_ff  <= req_tdata[73];
      end
   end

   // state
   nav_state_type      nav_ff, nav_in;
   logic [2:0]         slot_ff, slot_in;
   logic               seen_ff, seen_in, have_cmd_ff, have_cmd_in;
   logic               warned_x_ff, warned_x_in, warned_y_ff, warned_y_in;
   logic signed [13:0] cmd_err_x_ff, cmd_err_x_in, cmd_err_y_ff, cmd_err_y_in;
   logic [3:0]         worse_x_ff, worse_x_in, worse_y_ff, worse_y_in;
   logic [15:0]        ms_seen_ff, ms_seen_in, ms_cmd_ff, ms_cmd_in;

   // per-axis error and correction
   logic signed [13:0] ex, ey;
   logic [13:0]        abs_ex, abs_ey, lim;
   logic signed [29:0] prod_x, prod_y;
   logic signed [30:0] rnd_x, rnd_y;
   logic signed [15:0] sx, sy;
   logic signed [23:0] cx, cy;
   point_type          pt;

   assign ex     = $signed({1'b0, s1_obj_x_ff, 1'b0}) - $signed({2'b0, frame_width_ff});
   assign ey     = $signed({1'b0, s1_obj_y_ff, 1'b0}) - $signed({2'b0, frame_height_ff});
   assign abs_ex = abs14(ex);
   assign abs_ey = abs14(ey);
   assign lim    = (nav_ff == ST_HOVER) ? {1'b0, hover_release_ff, 1'b0}
                                        : {1'b0, center_tol_ff, 1'b0};
   assign prod_x = ex * gain_x_ff;
   assign prod_y = ey * gain_y_ff;
   assign rnd_x  = 31'(prod_x) + 31'sd128;
   assign rnd_y  = 31'(prod_y) + 31'sd128;
   assign sx     = clamp_shift(rnd_x[30:8]);
   assign sy     = clamp_shift(rnd_y[30:8]);
   assign cx     = sat24(25'(s1_pos_x_ff) + 25'(sx));
   assign cy     = sat24(25'(s1_pos_y_ff) + 25'(sy));
   assign pt     = patrol_point(slot_ff);

   // result fields
   logic               abort_in, move_in, wx_in, wy_in;
   logic signed [23:0] tx_in, ty_in;
   logic signed [15:0] shx_in, shy_in;
   logic               hold;

   always_comb begin
      nav_in      = nav_ff;
      slot_in     = slot_ff;
      seen_in     = seen_ff;
      have_cmd_in = have_cmd_ff;
      warned_x_in = warned_x_ff;
      warned_y_in = warned_y_ff;
      cmd_err_x_in = cmd_err_x_ff;
      cmd_err_y_in = cmd_err_y_ff;
      worse_x_in  = worse_x_ff;
      worse_y_in  = worse_y_ff;
      ms_seen_in  = ms_seen_ff;
      ms_cmd_in   = ms_cmd_ff;
      abort_in    = 1'b0;
      move_in     = 1'b0;
      wx_in       = 1'b0;
      wy_in       = 1'b0;
      tx_in       = '0;
      ty_in       = '0;
      shx_in      = '0;
      shy_in      = '0;
      hold        = 1'b0;
      if (s1_kind_ff == KIND_TICK) begin
         if (ms_seen_ff != 16'hffff) ms_seen_in = ms_seen_ff + 16'd1;
         if (ms_cmd_ff != 16'hffff) ms_cmd_in = ms_cmd_ff + 16'd1;
      end else if (s1_found_ff) begin
         ms_seen_in = '0;
         seen_in    = 1'b1;
         if (abs_ex <= lim && abs_ey <= lim) begin
            if (nav_ff != ST_HOVER) begin
               abort_in    = 1'b1;
               nav_in      = ST_HOVER;
               have_cmd_in = 1'b0;
               worse_x_in  = '0;
               worse_y_in  = '0;
            end
         end else begin
            if (nav_ff == ST_PATROL) begin
               abort_in    = 1'b1;
               have_cmd_in = 1'b0;
               worse_x_in  = '0;
               worse_y_in  = '0;
            end
            nav_in = ST_APPROACH;
            if (!(have_cmd_in && ms_cmd_ff < reaim_ms_ff)) begin
               if (have_cmd_in) begin
                  worse_x_in = strike(worse_x_ff, abs_ex, abs14(cmd_err_x_ff));
                  worse_y_in = strike(worse_y_ff, abs_ey, abs14(cmd_err_y_ff));
                  if (worse_x_in >= 4'(STRIKES) && !warned_x_ff) begin
                     warned_x_in = 1'b1;
                     wx_in       = 1'b1;
                  end
                  if (worse_y_in >= 4'(STRIKES) && !warned_y_ff) begin
                     warned_y_in = 1'b1;
                     wy_in       = 1'b1;
                  end
               end
               shx_in       = sx;
               shy_in       = sy;
               tx_in        = cx;
               ty_in        = cy;
               move_in      = 1'b1;
               cmd_err_x_in = ex;
               cmd_err_y_in = ey;
               have_cmd_in  = 1'b1;
               ms_cmd_in    = '0;
            end
         end
      end else begin
         if (nav_ff != ST_PATROL && seen_ff) begin
            if (ms_seen_ff < lost_grace_ms_ff) begin
               hold = 1'b1;
            end else begin
               nav_in      = ST_PATROL;
               have_cmd_in = 1'b0;
               worse_x_in  = '0;
               worse_y_in  = '0;
            end
         end
         if (!hold && !s1_busy_ff) begin
            if (nav_in != nav_ff) begin
               tx_in = -PHX;
               ty_in = -PHY;
               slot_in = 3'd1;
            end else begin
               tx_in   = pt.x;
               ty_in   = pt.y;
               slot_in = (slot_ff >= 3'd5) ? 3'd0 : slot_ff + 3'd1;
            end
            move_in = 1'b1;
         end else if (nav_in != nav_ff) begin
            slot_in = 3'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nav_ff       <= ST_PATROL;
         slot_ff      <= '0;
         seen_ff      <= 1'b0;
         have_cmd_ff  <= 1'b0;
         warned_x_ff  <= 1'b0;
         warned_y_ff  <= 1'b0;
         cmd_err_x_ff <= '0;
         cmd_err_y_ff <= '0;
         worse_x_ff   <= '0;
         worse_y_ff   <= '0;
         ms_seen_ff   <= '0;
         ms_cmd_ff    <= '0;
      end else if (s1_fire) begin
         nav_ff       <= nav_in;
         slot_ff      <= slot_in;
         seen_ff      <= seen_in;
         have_cmd_ff  <= have_cmd_in;
         warned_x_ff  <= warned_x_in;
         warned_y_ff  <= warned_y_in;
         cmd_err_x_ff <= cmd_err_x_in;
         cmd_err_y_ff <= cmd_err_y_in;
         worse_x_ff   <= worse_x_in;
         worse_y_ff   <= worse_y_in;
         ms_seen_ff   <= ms_seen_in;
         ms_cmd_ff    <= ms_cmd_in;
      end
   end

   // result register
   logic rsp_tvalid_ff, rsp_load;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff;

   assign rsp_load = s1_fire && s1_kind_ff == KIND_FRAME;

   always_ff @(posedge clock) begin
      if (reset) rsp_tvalid_ff <= 1'b0;
      else if (rsp_load) rsp_tvalid_ff <= 1'b1;
      else if (rsp_tready) rsp_tvalid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_tdata_ff <= {2'b0, wy_in, wx_in, shy_in, shx_in, ty_in, tx_in,
                          move_in, abort_in, mode_code(nav_in)};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule
`default_nettype wire

/* dv/nav_result_checker.sv */
// ----------------------------------------------------------------------------
// nav_result_checker
// tracks the navigator's mode machine from the accepted request beats and csr
// writes, and compares every result beat, field by field, in order
// ----------------------------------------------------------------------------
module nav_result_checker
   import tpn_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   csr_we,
   input  wire  [CSR_ADDR_W-1:0] csr_addr,
   input  wire  [CSR_DATA_W-1:0] csr_wdata,
   input  wire                   req_tvalid,
   input  wire                   req_tready,
   // found, obj_x, obj_y, pos_x, pos_y, busy, zero pad
   input  wire  [REQ_DATA_W-1:0] req_tdata,
   // kind
   input  wire                   req_tuser,
   input  wire                   rsp_tvalid,
   input  wire                   rsp_tready,
   // mode, abort_move, move_valid, target_x, target_y, shift_x, shift_y,
   // warn_x, warn_y, zero pad
   input  wire  [RSP_DATA_W-1:0] rsp_tdata,
   output int                    fail_count,
   output int                    pending,
   output int                    results_seen
);

   localparam int MS_SAT  = 65535;
   localparam int POS_TOP = 8388607;
   localparam int POS_BOT = -8388608;

   typedef struct packed {
      logic [1:0]         mode;
      logic               abort_move;
      logic               move_valid;
      logic signed [23:0] target_x;
      logic signed [23:0] target_y;
      logic signed [15:0] shift_x;
      logic signed [15:0] shift_y;
      logic               warn_x;
      logic               warn_y;
   } nav_result_type;

   nav_result_type nav_results_due[$];

   // register copies
   int frame_w, frame_h, center_tol, hover_rel, reaim, lost_grace, gain_x, gain_y;

   // navigator state
   logic [1:0] nav_mode;
   int         patrol_slot;
   bit         ever_seen, have_cmd, warned_x, warned_y;
   int         cmd_ex, cmd_ey, worse_x, worse_y, ms_seen, ms_cmd;

   function automatic int magnitude(input int v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic int correction(input int err, input int gain);
      longint p;
      p = (longint'(err) * gain + 128) >>> 8;
      if (p > MAX_SHIFT) p = MAX_SHIFT;
      if (p < -MAX_SHIFT) p = -MAX_SHIFT;
      return int'(p);
   endfunction

   function automatic int sat_pos(input longint v);
      if (v > POS_TOP) return POS_TOP;
      if (v < POS_BOT) return POS_BOT;
      return int'(v);
   endfunction

   function automatic int next_strike(input int cnt, input int err, input int prev);
      if (magnitude(err) > magnitude(prev) + WORSE_MARGIN) return (cnt < 15) ? cnt + 1 : 15;
      return 0;
   endfunction

   task automatic drop_command();
      have_cmd = 1'b0;
      worse_x  = 0;
      worse_y  = 0;
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      fail_count++;
      $display("%0t: result %0d %s: got %0d, predicted %0d", $realtime, results_seen,
               what, got, want);
   endtask

   task automatic advance_navigator(input logic kind, input logic [REQ_DATA_W-1:0] d);
      nav_result_type     r;
      logic signed [23:0] pos_x, pos_y;
      int                 ex, ey, lim, sx, sy;
      bit                 hold;
      r = '0;
      if (kind == KIND_TICK) begin
         if (ms_seen < MS_SAT) ms_seen++;
         if (ms_cmd < MS_SAT) ms_cmd++;
         return;
      end
      pos_x = d[48:25];
      pos_y = d[72:49];
      if (d[0]) begin
         ms_seen   = 0;
         ever_seen = 1'b1;
         ex  = 2 * int'(d[12:1]) - frame_w;
         ey  = 2 * int'(d[24:13]) - frame_h;
         lim = 2 * ((nav_mode == MODE_HOVER) ? hover_rel : center_tol);
         if (magnitude(ex) <= lim && magnitude(ey) <= lim) begin
            if (nav_mode != MODE_HOVER) begin
               r.abort_move = 1'b1;
               nav_mode     = MODE_HOVER;
               drop_command();
            end
         end else begin
            if (nav_mode == MODE_PATROL) begin
               r.abort_move = 1'b1;
               drop_command();
            end
            nav_mode = MODE_APPROACH;
            if (!(have_cmd && ms_cmd < reaim)) begin
               if (have_cmd) begin
                  worse_x = next_strike(worse_x, ex, cmd_ex);
                  worse_y = next_strike(worse_y, ey, cmd_ey);
                  if (worse_x >= STRIKES && !warned_x) begin
                     warned_x = 1'b1;
                     r.warn_x = 1'b1;
                  end
                  if (worse_y >= STRIKES && !warned_y) begin
                     warned_y = 1'b1;
                     r.warn_y = 1'b1;
                  end
               end
               sx = correction(ex, gain_x);
               sy = correction(ey, gain_y);
               r.shift_x    = 16'(sx);
               r.shift_y    = 16'(sy);
               r.target_x   = 24'(sat_pos(longint'(pos_x) + sx));
               r.target_y   = 24'(sat_pos(longint'(pos_y) + sy));
               r.move_valid = 1'b1;
               cmd_ex   = ex;
               cmd_ey   = ey;
               have_cmd = 1'b1;
               ms_cmd   = 0;
            end
         end
      end else begin
         hold = 1'b0;
         if (nav_mode != MODE_PATROL && ever_seen) begin
            if (ms_seen < lost_grace) begin
               hold = 1'b1;
            end else begin
               nav_mode    = MODE_PATROL;
               patrol_slot = 0;
               drop_command();
            end
         end
         if (!hold && !d[73]) begin
            case (patrol_slot)
               0: begin
                  r.target_x = -24'(SWEEP_HALF_X);
                  r.target_y = -24'(SWEEP_HALF_Y);
               end
               1: begin
                  r.target_x = 24'(SWEEP_HALF_X);
                  r.target_y = 24'(SWEEP_HALF_Y);
               end
               3: begin
                  r.target_x = 24'(SWEEP_HALF_X);
                  r.target_y = -24'(SWEEP_HALF_Y);
               end
               4: begin
                  r.target_x = -24'(SWEEP_HALF_X);
                  r.target_y = 24'(SWEEP_HALF_Y);
               end
               default: begin
                  r.target_x = '0;
                  r.target_y = '0;
               end
            endcase
            r.move_valid = 1'b1;
            patrol_slot  = (patrol_slot + 1) % 6;
         end
      end
      r.mode = nav_mode;
      nav_results_due.push_back(r);
   endtask

   always @(posedge clock) begin
      nav_result_type seen, want;
      if (reset) begin
         frame_w     = 1280;
         frame_h     = 720;
         center_tol  = 20;
         hover_rel   = 40;
         reaim       = 200;
         lost_grace  = 2000;
         gain_x      = 256;
         gain_y      = 256;
         nav_mode    = MODE_PATROL;
         patrol_slot = 0;
         ever_seen   = 1'b0;
         warned_x    = 1'b0;
         warned_y    = 1'b0;
         cmd_ex      = 0;
         cmd_ey      = 0;
         ms_seen     = 0;
         ms_cmd      = 0;
         drop_command();
         nav_results_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_FRAME_WIDTH:   frame_w    = int'(csr_wdata[11:0]);
               CSR_FRAME_HEIGHT:  frame_h    = int'(csr_wdata[11:0]);
               CSR_CENTER_TOL:    center_tol = int'(csr_wdata[11:0]);
               CSR_HOVER_RELEASE: hover_rel  = int'(csr_wdata[11:0]);
               CSR_REAIM_MS:      reaim      = int'(csr_wdata);
               CSR_LOST_GRACE_MS: lost_grace = int'(csr_wdata);
               CSR_GAIN_X:        gain_x     = int'($signed(csr_wdata));
               CSR_GAIN_Y:        gain_y     = int'($signed(csr_wdata));
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.mode       = rsp_tdata[1:0];
            seen.abort_move = rsp_tdata[2];
            seen.move_valid = rsp_tdata[3];
            seen.target_x   = rsp_tdata[27:4];
            seen.target_y   = rsp_tdata[51:28];
            seen.shift_x    = rsp_tdata[67:52];
            seen.shift_y    = rsp_tdata[83:68];
            seen.warn_x     = rsp_tdata[84];
            seen.warn_y     = rsp_tdata[85];
            results_seen++;
            if (nav_results_due.size() == 0) begin
               report_mismatch("arrived with none outstanding", 1, 0);
            end else begin
               want = nav_results_due.pop_front();
               if (seen.mode !== want.mode)
                  report_mismatch("mode", seen.mode, want.mode);
               if (seen.abort_move !== want.abort_move)
                  report_mismatch("abort_move", seen.abort_move, want.abort_move);
               if (seen.move_valid !== want.move_valid)
                  report_mismatch("move_valid", seen.move_valid, want.move_valid);
               if (seen.target_x !== want.target_x)
                  report_mismatch("target_x", seen.target_x, want.target_x);
               if (seen.target_y !== want.target_y)
                  report_mismatch("target_y", seen.target_y, want.target_y);
               if (seen.shift_x !== want.shift_x)
                  report_mismatch("shift_x", seen.shift_x, want.shift_x);
               if (seen.shift_y !== want.shift_y)
                  report_mismatch("shift_y", seen.shift_y, want.shift_y);
               if (seen.warn_x !== want.warn_x)
                  report_mismatch("warn_x", seen.warn_x, want.warn_x);
               if (seen.warn_y !== want.warn_y)
                  report_mismatch("warn_y", seen.warn_y, want.warn_y);
            end
         end
         if (req_tvalid && req_tready) advance_navigator(req_tuser, req_tdata);
      end
      pending = nav_results_due.size();
   end

endmodule

/* dv/tb_track_patrol_navigator.sv */
// ----------------------------------------------------------------------------
// tb_track_patrol_navigator
// drives tick and frame beats and csr settings into the navigator: a directed
// walk through patrol, approach, hover, hold-off, grace and wrong-way cases,
// then random phases of ticks, found and lost frames and occasional drift
// runs under changing settings and stall patterns
// ----------------------------------------------------------------------------
module tb_track_patrol_navigator
   import tpn_pkg::*;
;

   localparam int     HALF_PERIOD  = 5;
   localparam longint LIMIT_CYCLES = 1_000_000;
   localparam int     PHASE_BEATS  = 215;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int fail_count, pending, results_seen;

   int snd_idle = 29;
   int rcv_idle = 77;
   int beat_count, tick_count, frame_count, settings_count;

   // settings as last written
   int frame_w = 1280;
   int frame_h = 720;
   int center_tol = 20;
   int hover_rel = 40;
   int reaim = 200;

   track_patrol_navigator i_dut (
      .clock, .reset, .csr_we, .csr_addr, .csr_wdata,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

   nav_result_checker i_check (
      .clock, .reset, .csr_we, .csr_addr, .csr_wdata,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .fail_count, .pending, .results_seen
   );

   always #HALF_PERIOD clock = ~clock;

   always @(negedge clock) rsp_tready <= ($urandom_range(0, 99) >= rcv_idle);

   initial begin
      #(LIMIT_CYCLES * 2 * HALF_PERIOD);
      $display("timeout with %0d results outstanding", pending);
      $display("[track_patrol_navigator] ERROR");
      $finish;
   end

   task automatic send_beat(input logic kind, input logic [REQ_DATA_W-1:0] data);
      while ($urandom_range(0, 99) < snd_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      beat_count++;
      if (kind == KIND_TICK) tick_count++;
      else frame_count++;
   endtask

   task automatic tick_beat();
      send_beat(KIND_TICK, REQ_DATA_W'({$urandom, $urandom, $urandom}));
   endtask

   task automatic frame_beat(input logic found, input int ox, input int oy,
                             input int px, input int py, input logic busy);
      send_beat(KIND_FRAME, REQ_DATA_W'({busy, 24'(py), 24'(px), 12'(oy), 12'(ox), found}));
   endtask

   // stop sending and let every result and the pipeline drain
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr, input int value);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= CSR_DATA_W'(value);
      @(negedge clock);
   endtask

   task automatic apply_settings(input int fw, input int fh, input int tol, input int rel,
                                 input int reaim_ms, input int grace, input int gx,
                                 input int gy);
      drain();
      frame_w    = fw;
      frame_h    = fh;
      center_tol = tol;
      hover_rel  = rel;
      reaim      = reaim_ms;
      write_csr(CSR_FRAME_WIDTH, fw);
      write_csr(CSR_FRAME_HEIGHT, fh);
      write_csr(CSR_CENTER_TOL, tol);
      write_csr(CSR_HOVER_RELEASE, rel);
      write_csr(CSR_REAIM_MS, reaim_ms);
      write_csr(CSR_LOST_GRACE_MS, grace);
      write_csr(CSR_GAIN_X, gx);
      write_csr(CSR_GAIN_Y, gy);
      csr_we <= 1'b0;
      settings_count++;
   endtask

   function automatic int clamp_px(input int v);
      return (v < 0) ? 0 : ((v > 4095) ? 4095 : v);
   endfunction

   function automatic int pick_pixel(input int size, input int band);
      if ($urandom_range(0, 9) < 2) return $urandom_range(0, 4095);
      if ($urandom_range(0, 1)) return clamp_px(size / 2 + int'($urandom_range(0, band)));
      return clamp_px(size / 2 - int'($urandom_range(0, band)));
   endfunction

   function automatic int pick_pos();
      logic signed [23:0] p;
      case ($urandom_range(0, 9))
         0, 1:    p = 24'($urandom);
         2:       p = 24'sh7fffff - 24'($urandom_range(0, 900));
         3:       p = 24'sh800000 + 24'($urandom_range(0, 900));
         default: p = 24'(int'($urandom_range(0, 40000)) - 20000);
      endcase
      return p;
   endfunction

   function automatic int pick_gain();
      if ($urandom_range(0, 3) == 0) return int'($signed(16'($urandom)));
      return int'($urandom_range(0, 1024)) - 512;
   endfunction

   // error grows step by step, frames spaced by the re-aim time in ticks, at most 10
   task automatic drift_run();
      int dir_x, dir_y, base, step, gap, k;
      dir_x = $urandom_range(0, 1) ? 1 : -1;
      dir_y = $urandom_range(0, 1) ? 1 : -1;
      base  = center_tol + int'($urandom_range(2, 30));
      step  = $urandom_range(1, 24);
      gap   = (reaim > 10) ? 10 : reaim;
      for (k = 0; k < 6; k++) begin
         repeat (gap) tick_beat();
         frame_beat(1'b1, clamp_px(frame_w / 2 + dir_x * (base + k * step)),
                    clamp_px(frame_h / 2 + dir_y * (base + k * step / 2)),
                    pick_pos(), pick_pos(), 1'b0);
      end
   endtask

   task automatic random_phase(input int n);
      int stop, r, band;
      stop = beat_count + n;
      while (beat_count < stop) begin
         r    = $urandom_range(0, 99);
         band = $urandom_range(0, 1) ? hover_rel + 4 : 400;
         if (r < 5)
            drift_run();
         else if (r < 44)
            tick_beat();
         else if (r < 58)
            frame_beat(1'b0, $urandom_range(0, 4095), $urandom_range(0, 4095),
                       pick_pos(), pick_pos(), $urandom_range(0, 1));
         else
            frame_beat(1'b1, pick_pixel(frame_w, band), pick_pixel(frame_h, band),
                       pick_pos(), pick_pos(), $urandom_range(0, 1));
      end
   endtask

   task automatic random_settings();
      int fw, fh, tol;
      fw  = $urandom_range(64, 2048);
      fh  = $urandom_range(64, 2048);
      tol = $urandom_range(0, 60);
      apply_settings(fw, fh, tol, tol + int'($urandom_range(0, 60)), $urandom_range(0, 6),
                     $urandom_range(0, 25), pick_gain(), pick_gain());
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: patrol, hover entry, release band, first aim, hold-off
      frame_beat(1'b0, 0, 0, 0, 0, 1'b0);
      frame_beat(1'b0, 0, 0, 0, 0, 1'b1);
      frame_beat(1'b1, 640, 360, 100, -100, 1'b0);
      frame_beat(1'b1, 660, 360, 100, -100, 1'b1);
      frame_beat(1'b1, 700, 360, 8388607, 0, 1'b0);
      frame_beat(1'b1, 4095, 4095, -8388608, -8388608, 1'b0);

      // short re-aim and grace: clamped shift, then wrong way on both axes
      apply_settings(1280, 720, 20, 40, 1, 3, 256, 256);
      tick_beat();
      frame_beat(1'b1, 0, 0, -8388608, -8388608, 1'b0);
      tick_beat();
      frame_beat(1'b1, 1000, 360, 0, 0, 1'b0);
      tick_beat();
      frame_beat(1'b1, 1500, 500, 0, 0, 1'b0);
      tick_beat();
      frame_beat(1'b1, 2500, 700, 0, 0, 1'b0);
      tick_beat();
      frame_beat(1'b1, 4095, 1000, 0, 0, 1'b0);
      frame_beat(1'b1, 4095, 1000, 0, 0, 1'b0);

      // lost object: hold inside grace, back to patrol after it
      frame_beat(1'b0, 0, 0, 0, 0, 1'b0);
      repeat (3) tick_beat();
      frame_beat(1'b0, 0, 0, 0, 0, 1'b1);
      frame_beat(1'b0, 0, 0, 0, 0, 1'b0);
      frame_beat(1'b1, 100, 100, 5, 5, 1'b0);
      frame_beat(1'b1, 640, 360, 5, 5, 1'b0);
      frame_beat(1'b1, 1000, 360, 5, 5, 1'b0);

      apply_settings(1280, 720, 20, 40, 3, 10, 256, 256);
      random_phase(PHASE_BEATS);
      apply_settings(4095, 4095, 0, 0, 0, 0, 32767, -32768);
      random_phase(PHASE_BEATS);
      apply_settings(1, 1, 4095, 4095, 1, 1, -32768, 32767);
      random_phase(PHASE_BEATS);

      snd_idle = 77;
      rcv_idle = 29;
      apply_settings(0, 0, 5, 60, 2, 6, -256, 128);
      random_phase(PHASE_BEATS);
      random_settings();
      random_phase(PHASE_BEATS);
      random_settings();
      random_phase(PHASE_BEATS);

      snd_idle = 0;
      rcv_idle = 0;
      random_settings();
      random_phase(PHASE_BEATS);
      random_settings();
      random_phase(PHASE_BEATS);

      drain();
      repeat (10) @(negedge clock);
      $display("covered %0d frame and %0d tick beats, %0d results compared", frame_count,
               tick_count, results_seen);
      $display("over %0d csr settings incl. range extremes and three stall patterns",
               settings_count);
      if (fail_count == 0 && pending == 0) begin
         $display("[track_patrol_navigator] OK");
      end else begin
         $display("[track_patrol_navigator] ERROR");
      end
      $finish;
   end

endmodule
